/* design/ami_pkg.sv */
// Shared widths, types and register codes for the affine multiply-by-inverse core.
// No dependencies; imported by ami_div_pipe and affine_multiply_by_inverse_core.
package ami_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int FRAC_BITS_MAX = 24;

  localparam int DATA_W = 32;                 // one Q-format transform entry
  localparam int PROD_W = 2 * DATA_W;         // entry times entry
  localparam int WIDE_W = PROD_W + 1;         // difference of two products
  localparam int PART_W = WIDE_W;             // split partial product
  localparam int NUM_W  = 100;                // signed numerator
  localparam int MAG_W  = NUM_W - 1;          // numerator magnitude
  localparam int DEN_W  = PROD_W;             // determinant magnitude
  localparam int QUO_W  = DATA_W;             // quotient bits resolved
  localparam int DIV_LAT = QUO_W + 2;         // divider register stages

  localparam int THR_W = 17;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(7);

  localparam int APB_W  = 32;
  localparam int ADDR_W = 3;
  localparam logic REG_DET_THRESHOLD = 1'b0;  // paddr[2] code

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [DEN_W-1:0] den;
    logic             neg;
  } ami_div_in_t;

endpackage

/* design/ami_div_pipe.sv */
// Pipelined restoring divider with round-half-away and signed saturation.
// Depends on ami_pkg (widths, ami_div_in_t).
module ami_div_pipe (
  input  logic                                clk,
  input  logic                                en,
  input  ami_pkg::ami_div_in_t                din,
  output logic signed [ami_pkg::QUO_W-1:0]    quo
);
  import ami_pkg::*;

  logic [DEN_W-1:0] rem_q [0:QUO_W];
  logic [QUO_W-1:0] low_q [0:QUO_W];
  logic [QUO_W-1:0] quo_q [0:QUO_W];
  logic [DEN_W-1:0] den_q [0:QUO_W];
  logic             neg_q [0:QUO_W];
  logic             ovf_q [0:QUO_W];

  // quotient at or above 2^QUO_W saturates regardless of rounding
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_q[0] <= din.mag[MAG_W-1:QUO_W] >= (MAG_W-QUO_W)'(din.den);
      rem_q[0] <= din.mag[QUO_W+DEN_W-1:QUO_W];
      low_q[0] <= din.mag[QUO_W-1:0];
      quo_q[0] <= '0;
      den_q[0] <= din.den;
      neg_q[0] <= din.neg;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [DEN_W:0] r2;
    logic           ge;
    always_comb begin
      r2 = {rem_q[k], low_q[k][QUO_W-1]};
      ge = r2 >= {1'b0, den_q[k]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1] <= ge ? DEN_W'(r2 - {1'b0, den_q[k]}) : DEN_W'(r2);
        low_q[k+1] <= {low_q[k][QUO_W-2:0], 1'b0};
        quo_q[k+1] <= {quo_q[k][QUO_W-2:0], ge};
        den_q[k+1] <= den_q[k];
        neg_q[k+1] <= neg_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  localparam logic [QUO_W:0] POS_LIM = {2'b00, {(QUO_W-1){1'b1}}};
  localparam logic [QUO_W:0] NEG_LIM = {2'b01, {(QUO_W-1){1'b0}}};

  logic           up;
  logic [QUO_W:0] q1;
  always_comb begin
    up = {rem_q[QUO_W], 1'b0} >= {1'b0, den_q[QUO_W]};
    q1 = {1'b0, quo_q[QUO_W]} + (QUO_W+1)'(up);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_q[QUO_W]) begin
        if (ovf_q[QUO_W] || q1 > NEG_LIM) quo <= NEG_LIM[QUO_W-1:0];
        else quo <= -q1[QUO_W-1:0];
      end else begin
        if (ovf_q[QUO_W] || q1 > POS_LIM) quo <= POS_LIM[QUO_W-1:0];
        else quo <= q1[QUO_W-1:0];
      end
    end
  end

endmodule

/* design/affine_multiply_by_inverse_core.sv */
// Top level: left affine transform times the inverse of the right one.
// Depends on ami_pkg and ami_div_pipe.
//
// The core takes one transaction per cycle while the output is not stalled:
// six front stages form the products, determinant, numerators and
// magnitudes, then six parallel 34-stage dividers resolve one quotient bit
// per stage, round to nearest (ties away from zero) and saturate. The whole
// pipeline holds while a finished result is stalled at the output; bubbles
// move with their valid bits. When |det| of the right transform is zero or
// below det_threshold (scaled by 2^FRAC_BITS), the left entries are sent
// through the same dividers over 2^FRAC_BITS, so they come out unchanged and
// singular_passthrough is set. det_threshold sits at APB byte address 0.
module affine_multiply_by_inverse_core #(
  parameter int FRAC_BITS = ami_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ami_pkg::ADDR_W-1:0]           paddr,
  input  logic [ami_pkg::APB_W-1:0]            pwdata,
  output logic [ami_pkg::APB_W-1:0]            prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [ami_pkg::DATA_W-1:0]    left_r0c0,
  input  logic signed [ami_pkg::DATA_W-1:0]    left_r0c1,
  input  logic signed [ami_pkg::DATA_W-1:0]    left_r0tx,
  input  logic signed [ami_pkg::DATA_W-1:0]    left_r1c0,
  input  logic signed [ami_pkg::DATA_W-1:0]    left_r1c1,
  input  logic signed [ami_pkg::DATA_W-1:0]    left_r1ty,
  input  logic signed [ami_pkg::DATA_W-1:0]    right_r0c0,
  input  logic signed [ami_pkg::DATA_W-1:0]    right_r0c1,
  input  logic signed [ami_pkg::DATA_W-1:0]    right_r0tx,
  input  logic signed [ami_pkg::DATA_W-1:0]    right_r1c0,
  input  logic signed [ami_pkg::DATA_W-1:0]    right_r1c1,
  input  logic signed [ami_pkg::DATA_W-1:0]    right_r1ty,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [ami_pkg::DATA_W-1:0]    prod_r0c0,
  output logic signed [ami_pkg::DATA_W-1:0]    prod_r0c1,
  output logic signed [ami_pkg::DATA_W-1:0]    prod_r0tx,
  output logic signed [ami_pkg::DATA_W-1:0]    prod_r1c0,
  output logic signed [ami_pkg::DATA_W-1:0]    prod_r1c1,
  output logic signed [ami_pkg::DATA_W-1:0]    prod_r1ty,
  output logic                                 singular_passthrough
);
  import ami_pkg::*;

  localparam int FRONT = 6;
  localparam int TOTAL = FRONT + DIV_LAT;

  // ---------------- configuration register ----------------
  logic [THR_W-1:0] det_threshold;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_threshold <= THR_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_DET_THRESHOLD) begin
      det_threshold <= pwdata[THR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DET_THRESHOLD) prdata = APB_W'(det_threshold);
  end

  // ---------------- flow control ----------------
  // Advance every stage unless a finished result is held at the output.
  logic             en;
  logic [TOTAL-1:0] vld;

  assign en        = !(vld[TOTAL-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[TOTAL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL-2:0], in_valid};
    end
  end

  // ---------------- stage 1: entry products ----------------
  logic signed [DATA_W-1:0] a_in [0:5];
  logic signed [DATA_W-1:0] b_in [0:5];

  assign a_in = '{left_r0c0, left_r0c1, left_r0tx, left_r1c0, left_r1c1, left_r1ty};
  assign b_in = '{right_r0c0, right_r0c1, right_r0tx, right_r1c0, right_r1c1, right_r1ty};

  logic signed [PROD_W-1:0] s1_pb [0:5];   // b products for D, Tx, Ty
  logic signed [PROD_W-1:0] s1_pa [0:7];   // a*b products for linear entries
  logic signed [DATA_W-1:0] s1_a  [0:5];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pb[0] <= b_in[0] * b_in[4];
      s1_pb[1] <= b_in[1] * b_in[3];
      s1_pb[2] <= b_in[1] * b_in[5];
      s1_pb[3] <= b_in[4] * b_in[2];
      s1_pb[4] <= b_in[3] * b_in[2];
      s1_pb[5] <= b_in[0] * b_in[5];
      for (int r = 0; r < 2; r++) begin
        s1_pa[4*r]   <= a_in[3*r]   * b_in[4];
        s1_pa[4*r+1] <= a_in[3*r+1] * b_in[3];
        s1_pa[4*r+2] <= a_in[3*r+1] * b_in[0];
        s1_pa[4*r+3] <= a_in[3*r]   * b_in[1];
      end
      s1_a <= a_in;
    end
  end

  // ---------------- stage 2: determinant and differences ----------------
  logic signed [WIDE_W-1:0] s2_d, s2_tx, s2_ty;
  logic signed [WIDE_W-1:0] s2_nl [0:3];  // r0c0, r0c1, r1c0, r1c1 numerators
  logic signed [DATA_W-1:0] s2_a  [0:5];

  always_ff @(posedge clk) begin
    if (en) begin
      s2_d  <= WIDE_W'(s1_pb[0]) - WIDE_W'(s1_pb[1]);
      s2_tx <= WIDE_W'(s1_pb[2]) - WIDE_W'(s1_pb[3]);
      s2_ty <= WIDE_W'(s1_pb[4]) - WIDE_W'(s1_pb[5]);
      for (int j = 0; j < 4; j++) begin
        s2_nl[j] <= WIDE_W'(s1_pa[2*j]) - WIDE_W'(s1_pa[2*j+1]);
      end
      s2_a <= s1_a;
    end
  end

  // ---------------- stage 3: split products, |D| ----------------
  // Translation terms Tx*a, Ty*a, D*a; each wide factor is split at bit 32.
  logic signed [WIDE_W-1:0] t_fac [0:5];
  logic signed [DATA_W-1:0] t_mul [0:5];

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      t_fac[3*r]   = s2_tx;
      t_fac[3*r+1] = s2_ty;
      t_fac[3*r+2] = s2_d;
      t_mul[3*r]   = s2_a[3*r];
      t_mul[3*r+1] = s2_a[3*r+1];
      t_mul[3*r+2] = s2_a[3*r+2];
    end
  end

  logic signed [PART_W-1:0] s3_lo [0:5];
  logic signed [PART_W-1:0] s3_hi [0:5];
  logic        [DEN_W-1:0]  s3_md;
  logic                     s3_dneg;
  logic signed [WIDE_W-1:0] s3_nl [0:3];
  logic signed [DATA_W-1:0] s3_a  [0:5];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        s3_lo[j] <= $signed({1'b0, t_fac[j][DATA_W-1:0]}) * t_mul[j];
        s3_hi[j] <= $signed(t_fac[j][WIDE_W-1:DATA_W]) * t_mul[j];
      end
      s3_md   <= s2_d[WIDE_W-1] ? DEN_W'(-s2_d) : DEN_W'(s2_d);
      s3_dneg <= s2_d[WIDE_W-1];
      s3_nl   <= s2_nl;
      s3_a    <= s2_a;
    end
  end

  // ---------------- stage 4: recombine terms, singular test ----------------
  logic [DEN_W-1:0] thr_scaled;
  assign thr_scaled = DEN_W'(det_threshold) << FRAC_BITS;

  logic signed [NUM_W-1:0]  s4_t [0:5];
  logic        [DEN_W-1:0]  s4_md;
  logic                     s4_dneg;
  logic                     s4_sing;
  logic signed [WIDE_W-1:0] s4_nl [0:3];
  logic signed [DATA_W-1:0] s4_a  [0:5];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        s4_t[j] <= (NUM_W'(s3_hi[j]) <<< DATA_W) + NUM_W'(s3_lo[j]);
      end
      s4_md   <= s3_md;
      s4_dneg <= s3_dneg;
      s4_sing <= (s3_md == '0) || (s3_md < thr_scaled);
      s4_nl   <= s3_nl;
      s4_a    <= s3_a;
    end
  end

  // ---------------- stage 5: signed numerators ----------------
  logic signed [NUM_W-1:0]  s5_num [0:5];
  logic        [DEN_W-1:0]  s5_md;
  logic                     s5_dneg;
  logic                     s5_sing;
  logic signed [DATA_W-1:0] s5_a   [0:5];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 2; r++) begin
        s5_num[3*r]   <= NUM_W'(s4_nl[2*r])   <<< FRAC_BITS;
        s5_num[3*r+1] <= NUM_W'(s4_nl[2*r+1]) <<< FRAC_BITS;
        s5_num[3*r+2] <= s4_t[3*r] + s4_t[3*r+1] + s4_t[3*r+2];
      end
      s5_md   <= s4_md;
      s5_dneg <= s4_dneg;
      s5_sing <= s4_sing;
      s5_a    <= s4_a;
    end
  end

  // ---------------- stage 6: divider operands ----------------
  // Singular: divide the left entry, scaled up, by 2^FRAC_BITS.
  ami_div_in_t             s6_div [0:5];
  logic                    s6_sing;
  logic signed [NUM_W-1:0] sel_num [0:5];
  logic                    sel_neg [0:5];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      sel_num[j] = s5_sing ? (NUM_W'(s5_a[j]) <<< FRAC_BITS) : s5_num[j];
      sel_neg[j] = sel_num[j][NUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        s6_div[j].mag <= sel_neg[j] ? MAG_W'(-sel_num[j]) : MAG_W'(sel_num[j]);
        s6_div[j].den <= s5_sing ? (DEN_W'(1) << FRAC_BITS) : s5_md;
        s6_div[j].neg <= sel_neg[j] ^ (s5_dneg && !s5_sing);
      end
      s6_sing <= s5_sing;
    end
  end

  // ---------------- dividers ----------------
  logic signed [DATA_W-1:0] quo [0:5];

  for (genvar j = 0; j < 6; j++) begin : g_div
    ami_div_pipe u_div (
      .clk (clk),
      .en  (en),
      .din (s6_div[j]),
      .quo (quo[j])
    );
  end

  // Carry the singular flag alongside the divider stages.
  logic [TOTAL-1:FRONT] sing_pipe;

  always_ff @(posedge clk) begin
    if (en) begin
      sing_pipe <= {sing_pipe[TOTAL-2:FRONT], s6_sing};
    end
  end

  assign prod_r0c0            = quo[0];
  assign prod_r0c1            = quo[1];
  assign prod_r0tx            = quo[2];
  assign prod_r1c0            = quo[3];
  assign prod_r1c1            = quo[4];
  assign prod_r1ty            = quo[5];
  assign singular_passthrough = sing_pipe[TOTAL-1];

endmodule

/* dv/affine_multiply_by_inverse_core_test.sv */
// Testbench for affine_multiply_by_inverse_core: random and directed transform pairs.
// Depends on ami_pkg and the core RTL; a scoreboard class predicts and checks results.
module affine_multiply_by_inverse_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ami_pkg::*;

  typedef logic signed [DATA_W-1:0] entry_t;
  typedef logic signed [127:0] wide_t;

  // One transform pair and one product, entries in port order.
  typedef struct {
    entry_t v[12];
  } pair_t;
  typedef struct {
    entry_t v[6];
    logic   sing;
  } prod_t;

  // Computes left * inverse(right) exactly and keeps the products still owed.
  class inverse_product_board;
    prod_t        owed[$];
    logic [THR_W-1:0] thr;
    int           mismatches;

    function new();
      thr = THR_RESET;
      mismatches = 0;
    endfunction

    // Round to nearest, ties away from zero, clamp to the entry range.
    function entry_t quot(wide_t n, wide_t d);
      logic [127:0] mn, md, q, r;
      logic neg;
      neg = n[127] ^ d[127];
      mn = n[127] ? -n : n;
      md = d[127] ? -d : d;
      q = mn / md;
      r = mn % md;
      if (r >= md - r) q = q + 1;
      if (neg) return (q > 128'h8000_0000) ? entry_t'(32'h8000_0000) : entry_t'(-q[31:0]);
      return (q > 128'h7FFF_FFFF) ? entry_t'(32'h7FFF_FFFF) : entry_t'(q[31:0]);
    endfunction

    function void note_pair(pair_t p);
      wide_t a[6], b[6], det, mag, tx, ty, n;
      prod_t e;
      for (int k = 0; k < 6; k++) begin
        a[k] = p.v[k];
        b[k] = p.v[6 + k];
      end
      det = b[0] * b[4] - b[1] * b[3];
      mag = det[127] ? -det : det;
      e.sing = (mag == 0) || (mag < (wide_t'(thr) << 16));
      if (e.sing) begin
        for (int k = 0; k < 6; k++) e.v[k] = p.v[k];
      end else begin
        tx = b[1] * b[5] - b[4] * b[2];
        ty = b[3] * b[2] - b[0] * b[5];
        for (int k = 0; k < 6; k += 3) begin
          n = a[k] * b[4] - a[k + 1] * b[3];
          e.v[k] = quot(n <<< 16, det);
          n = a[k + 1] * b[0] - a[k] * b[1];
          e.v[k + 1] = quot(n <<< 16, det);
          n = tx * a[k] + ty * a[k + 1] + det * a[k + 2];
          e.v[k + 2] = quot(n, det);
        end
      end
      owed.push_back(e);
    endfunction

    function void check_product(prod_t got);
      prod_t e;
      bit bad;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected product, nothing owed");
        return;
      end
      e = owed.pop_front();
      bad = (got.sing !== e.sing);
      for (int k = 0; k < 6; k++) if (got.v[k] !== e.v[k]) bad = 1;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("product mismatch: exp %h %h %h %h %h %h s%b got %h %h %h %h %h %h s%b",
                   e.v[0], e.v[1], e.v[2], e.v[3], e.v[4], e.v[5], e.sing,
                   got.v[0], got.v[1], got.v[2], got.v[3], got.v[4], got.v[5], got.sing);
      end
    endfunction
  endclass

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_W-1:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_stall, out_valid, out_stall;
  entry_t src[12];
  entry_t prod[6];
  logic singular_passthrough;

  inverse_product_board board = new();
  int idle_cycles;
  bit calm_out;   // stretches where the output never stalls

  affine_multiply_by_inverse_core dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall,
    .left_r0c0(src[0]), .left_r0c1(src[1]), .left_r0tx(src[2]),
    .left_r1c0(src[3]), .left_r1c1(src[4]), .left_r1ty(src[5]),
    .right_r0c0(src[6]), .right_r0c1(src[7]), .right_r0tx(src[8]),
    .right_r1c0(src[9]), .right_r1c1(src[10]), .right_r1ty(src[11]),
    .out_valid, .out_stall,
    .prod_r0c0(prod[0]), .prod_r0c1(prod[1]), .prod_r0tx(prod[2]),
    .prod_r1c0(prod[3]), .prod_r1c1(prod[4]), .prod_r1ty(prod[5]),
    .singular_passthrough
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Watchdog: too long a stretch with no accepted transaction on either side ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receive side: draw a stall length per product, then hold stall low until one lands.
  initial begin
    int n;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      n = calm_out ? 0 : $urandom_range(0, 14);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      begin
        prod_t got;
        for (int k = 0; k < 6; k++) got.v[k] = prod[k];
        got.sing = singular_passthrough;
        board.check_product(got);
      end
    end
  end

  // APB write in setup and access phases; pready is always high so access lands at once.
  task automatic write_threshold(logic [APB_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_DET_THRESHOLD, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.thr = value[THR_W-1:0];
  endtask

  // Hold the sender until every owed product is back, then let the pipe drain.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  // Present one pair after a random gap unless no_gap is set; advance only on an accepted transaction.
  task automatic send_pair(pair_t p, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int k = 0; k < 12; k++) src[k] <= p.v[k];
    do @(posedge clk); while (!(in_valid && !in_stall));
    board.note_pair(p);
  endtask

  function automatic entry_t rand_entry();
    case ($urandom_range(0, 5))
      0: return entry_t'($urandom());
      1: begin
        case ($urandom_range(0, 4))
          0: return entry_t'(32'h8000_0000);
          1: return entry_t'(32'h7FFF_FFFF);
          2: return 0;
          3: return 1;
          default: return -1;
        endcase
      end
      default: return entry_t'($urandom_range(0, 32'h0008_0000)) - entry_t'(32'h0004_0000);
    endcase
  endfunction

  // Mostly ordinary transforms; some zero or near-threshold determinants.
  function automatic pair_t rand_pair(logic [THR_W-1:0] thr);
    pair_t p;
    for (int k = 0; k < 12; k++) p.v[k] = rand_entry();
    case ($urandom_range(0, 9))
      0: begin
        p.v[7] = 0;
        p.v[10] = 0;
      end
      1: begin
        p.v[6] = 32'sh0001_0000;
        p.v[7] = 0;
        p.v[10] = entry_t'(thr) + entry_t'($urandom_range(0, 2)) - 1;
      end
      default: ;
    endcase
    return p;
  endfunction

  function automatic pair_t mk(entry_t l0, l1, l2, l3, l4, l5, r0, r1, r2, r3, r4, r5);
    pair_t p;
    p.v = '{l0, l1, l2, l3, l4, l5, r0, r1, r2, r3, r4, r5};
    return p;
  endfunction

  initial begin
    localparam entry_t ONE = 32'sh0001_0000;
    localparam entry_t MX = 32'sh7FFF_FFFF;
    localparam entry_t MN = -32'sh7FFF_FFFF - 1;
    pair_t dir[$];
    logic [THR_W-1:0] settings[4];

    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0;
    calm_out = 0;
    idle_cycles = 0;
    for (int k = 0; k < 12; k++) src[k] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: identities, extremes, zero determinant, threshold edges,
    // rounding ties both signs, saturation through a tiny determinant.
    dir.push_back(mk(ONE, 0, 0, 0, ONE, 0, ONE, 0, 0, 0, ONE, 0));
    dir.push_back(mk(MX, MN, MX, MN, MX, MN, ONE, 0, 0, 0, ONE, 0));
    dir.push_back(mk(MX, MX, MX, MX, MX, MX, MX, MX, MX, MX, MX, MX));
    dir.push_back(mk(MN, MN, MN, MN, MN, MN, MN, 0, MN, 0, MN, MN));
    dir.push_back(mk(MN, MX, 1, -1, 0, 5, MN, MN, MN, MN, MN, MN));
    dir.push_back(mk(3, 5, 7, 9, 11, 13, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(3, -3, 5, -5, 1, -1, 2 * ONE, 0, 0, 0, 2 * ONE, 0));
    dir.push_back(mk(1, 2, 3, 4, 5, 6, ONE, 0, 0, 0, 7, 0));
    dir.push_back(mk(1, 2, 3, 4, 5, 6, ONE, 0, 0, 0, 6, 0));
    dir.push_back(mk(MX, MN, MX, MN, MX, MN, ONE, 0, 0, 0, 8, 0));
    dir.push_back(mk(ONE, 2 * ONE, -ONE, 3, -4, 5, 0, ONE, 3 * ONE, -ONE, 0, -7 * ONE));
    dir.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    dir.push_back(mk(12345, -54321, MX, MN, 99, -99, 3 * ONE, ONE, MX, ONE, 5 * ONE, MN));
    foreach (dir[i]) send_pair(dir[i], i % 2);

    // Threshold settings: reset value, zero, only the top bit set, random; stray upper bits dropped.
    settings = '{THR_RESET, 0, 17'h10000, 17'($urandom_range(1, 65536))};
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_threshold(ph == 3 ? (32'hFFFE_0000 | settings[ph]) : settings[ph]);
      for (int i = 0; i < 100; i++) begin
        calm_out = (i >= 40 && i < 60);
        send_pair(rand_pair(board.thr), i >= 40 && i < 60);
      end
    end
    calm_out = 0;

    drain();
    if (board.mismatches == 0 && board.owed.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
